>>> hw/rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned ELEM_W = 16;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned USED_W = 33;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd2;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

	localparam logic [ADDR_W-1:0] HEAP_BASE_RST  = 32'd0;
	localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 32'd65536;

	typedef struct packed {
		logic              operation;
		logic [ELEM_W-1:0] element_size;
		logic [ELEM_W-1:0] element_count;
		logic [ADDR_W-1:0] release_address;
	} req_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] clear_length;
	} rsp_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] length;
		logic              in_use;
	} blk_rec_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SCAN,
		S_HIT,
		S_MISS,
		S_RESP
	} ffba_state_t;

	typedef struct packed {
		logic load_req;   // capture accepted item
		logic mul;        // form product, restart scan
		logic scan_en;    // walk the block table
		logic hit_upd;    // update matched entry, build result
		logic miss_upd;   // grow or fail, build result
		logic res_invalid;// build invalid-argument result
		logic out_load;   // move pending result to output register
	} ffba_cmd_t;

	typedef struct packed {
		logic op_release;
		logic args_bad;
		logic hit;
		logic miss;
	} ffba_stat_t;

endpackage

>>> hw/rtl/ffba_ctrl.sv
// Control state machine of the first-fit block allocator.
module ffba_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  ffba_pkg::ffba_stat_t stat,
	output ffba_pkg::ffba_cmd_t  cmd
);
	import ffba_pkg::*;

	ffba_state_t state_q, state_d;
	logic        rsp_valid_q;
	logic        slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_MUL;
			end
			S_MUL: begin
				if (!stat.op_release && stat.args_bad) state_d = S_RESP;
				else state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat.hit) state_d = S_HIT;
				else if (stat.miss) state_d = S_MISS;
			end
			S_HIT:  state_d = S_RESP;
			S_MISS: state_d = S_RESP;
			S_RESP: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load_req = req_valid;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				cmd.res_invalid = !stat.op_release && stat.args_bad;
			end
			S_SCAN: cmd.scan_en = 1'b1;
			S_HIT:  cmd.hit_upd = 1'b1;
			S_MISS: cmd.miss_upd = 1'b1;
			S_RESP: cmd.out_load = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

>>> hw/rtl/ffba_dp.sv
// Datapath of the first-fit block allocator: block table, scan, heap top.
module ffba_dp #(
	parameter int unsigned TABLE_ENTRIES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ffba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ffba_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  ffba_pkg::req_item_t                 req,
	output ffba_pkg::rsp_item_t                 rsp,
	input  ffba_pkg::ffba_cmd_t                 cmd,
	output ffba_pkg::ffba_stat_t                stat
);
	import ffba_pkg::*;

	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	blk_rec_t          mem [TABLE_ENTRIES];
	blk_rec_t          rd_s1;
	logic              vld_s1;
	logic [IW-1:0]     idx_s1;
	logic [CW-1:0]     iss_q;
	logic [CW-1:0]     count_q;
	logic [USED_W-1:0] used_q;
	logic [ADDR_W-1:0] heap_base_q;
	logic [ADDR_W-1:0] heap_limit_q;
	req_item_t         req_q;
	logic [ADDR_W-1:0] total_q;
	rsp_item_t         res_q;
	rsp_item_t         rsp_q;

	logic              match;
	logic              issue;
	logic              fits;
	logic [USED_W:0]   grow_sum;
	logic [ADDR_W-1:0] grow_base;

	// match on the entry read last cycle
	always_comb begin
		if (req_q.operation == OP_RELEASE)
			match = vld_s1 && (rd_s1.base == req_q.release_address);
		else
			match = vld_s1 && !rd_s1.in_use && (rd_s1.length >= total_q);
	end

	assign issue = cmd.scan_en && !match && (iss_q < count_q);

	assign grow_sum  = {1'b0, used_q} + (USED_W+1)'(total_q);
	assign grow_base = heap_base_q + used_q[ADDR_W-1:0];
	assign fits      = (count_q < CW'(TABLE_ENTRIES)) &&
	                   (grow_sum <= (USED_W+1)'(heap_limit_q));

	assign stat.op_release = req_q.operation == OP_RELEASE;
	assign stat.args_bad   = (req_q.element_size == '0) || (req_q.element_count == '0);
	assign stat.hit        = match;
	assign stat.miss       = !vld_s1 && (iss_q == count_q);

	// table memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.hit_upd)
			mem[idx_s1] <= '{base: rd_s1.base, length: rd_s1.length,
			                 in_use: req_q.operation == OP_ALLOC};
		else if (cmd.miss_upd && req_q.operation == OP_ALLOC && fits)
			mem[count_q[IW-1:0]] <= '{base: grow_base, length: total_q, in_use: 1'b1};
		if (issue) begin
			rd_s1  <= mem[iss_q[IW-1:0]];
			idx_s1 <= iss_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= '0;
			vld_s1 <= 1'b0;
			count_q <= '0;
			used_q <= '0;
			heap_base_q <= HEAP_BASE_RST;
			heap_limit_q <= HEAP_LIMIT_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HEAP_BASE:  heap_base_q <= cfg_data;
					CFG_HEAP_LIMIT: heap_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.mul) begin
				iss_q <= '0;
				vld_s1 <= 1'b0;
			end else if (cmd.scan_en && !match) begin
				vld_s1 <= issue;
				if (issue) iss_q <= iss_q + CW'(1);
			end
			if (cmd.miss_upd && req_q.operation == OP_ALLOC && fits) begin
				count_q <= count_q + CW'(1);
				used_q <= grow_sum[USED_W-1:0];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;
		if (cmd.mul)
			total_q <= ADDR_W'(req_q.element_size) * ADDR_W'(req_q.element_count);
		if (cmd.res_invalid) res_q <= '{address: '0, status: ST_INVALID, clear_length: '0};
		if (cmd.hit_upd) begin
			if (req_q.operation == OP_ALLOC)
				res_q <= '{address: rd_s1.base, status: ST_OK, clear_length: total_q};
			else
				res_q <= '{address: '0, status: ST_OK, clear_length: '0};
		end
		if (cmd.miss_upd) begin
			if (req_q.operation == OP_ALLOC) begin
				if (fits)
					res_q <= '{address: grow_base, status: ST_OK, clear_length: total_q};
				else
					res_q <= '{address: '0, status: ST_NOMEM, clear_length: '0};
			end else begin
				res_q <= '{address: '0,
				           status: (req_q.release_address == '0) ? ST_OK : ST_UNKNOWN,
				           clear_length: '0};
			end
		end
		if (cmd.out_load) rsp_q <= res_q;
	end

	assign rsp = rsp_q;

endmodule

>>> hw/rtl/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator.
// Usage:
//   req channel (req_valid/req_ready/req) takes one item: allocate
//   element_size*element_count bytes, or release the block at
//   release_address. rsp channel (rsp_valid/rsp_ready/rsp) returns exactly
//   one item per request: address, status and clear_length.
//   Config port: cfg_we writes heap_base (index 0) or heap_limit (index 1)
//   at the clock edge; write only while no request is in flight.
// Timing:
//   One request at a time; the walk reads one table entry per cycle from
//   entry 0 and stops at the first match, or reads every created block
//   when none matches. Invalid allocations skip the walk. req_ready returns
//   in the same cycle that rsp_valid rises.
// Reset:
//   arst_n clears the entry count, heap usage and registers to defaults;
//   table contents need no clearing since only counted entries are read.
// Stall:
//   A finished item waits in the output register while the next request is
//   already accepted and worked on; the controller holds the new result
//   until the output register frees.
module first_fit_block_allocator_top #(
	parameter int unsigned TABLE_ENTRIES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  ffba_pkg::req_item_t             req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output ffba_pkg::rsp_item_t             rsp,
	input  logic                            cfg_we,
	input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ffba_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ffba_pkg::*;

	ffba_cmd_t  cmd;
	ffba_stat_t stat;

	// sequencing: accept, multiply, table walk, update, hand off
	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// block table, heap top and result registers
	ffba_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

>>> tb/first_fit_block_allocator_top_tb.sv
// Self-checking testbench for the first-fit block allocator top level.
`timescale 1ns / 1ps

module first_fit_block_allocator_top_tb;
	import ffba_pkg::*;

	localparam int TBL = 64;
	// Slowest legal run is ~1.2k items with long stalls on both sides;
	// this limit leaves a wide margin.
	localparam int LIMIT_CYCLES = 1000000;

	// One row of the directed stimulus: either a register write or an item,
	// optionally with the expected result written out by hand.
	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  cfg_idx;
		logic [CFG_DATA_W-1:0] cfg_val;
		req_item_t             item;
		logic                  fixed;
		rsp_item_t             fixed_rsp;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_item_t             req = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_item_t             rsp;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the allocator: block table, usage and registers.
	logic [ADDR_W-1:0] blk_base_m [TBL];
	logic [ADDR_W-1:0] blk_len_m [TBL];
	logic              blk_busy_m [TBL];
	int                blk_count_m = 0;
	logic [USED_W-1:0] used_m = '0;
	logic [ADDR_W-1:0] base_m = HEAP_BASE_RST;
	logic [ADDR_W-1:0] limit_m = HEAP_LIMIT_RST;

	rsp_item_t answers_due [$];
	int        mismatches = 0;
	int        rsp_seen = 0;
	int        cycles = 0;
	bit        calm = 1'b0;   // no idling on either side while set
	bit        squeeze_done = 1'b0;
	int        hold_left = 0;

	first_fit_block_allocator_top #(
		.TABLE_ENTRIES(TBL)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Work out the allocator's answer to one item and update the shadow state.
	function automatic rsp_item_t alloc_answer(req_item_t r);
		rsp_item_t         a;
		logic [ADDR_W-1:0] total;
		int                i;
		a = '0;
		if (r.operation == OP_RELEASE) begin
			// first matching base wins; freeing a free block is harmless
			for (i = 0; i < blk_count_m; i++) begin
				if (blk_base_m[i] == r.release_address) begin
					blk_busy_m[i] = 1'b0;
					a.status = ST_OK;
					return a;
				end
			end
			// no match: a null release is fine, anything else is unknown
			a.status = (r.release_address == '0) ? ST_OK : ST_UNKNOWN;
			return a;
		end
		if (r.element_size == '0 || r.element_count == '0) begin
			a.status = ST_INVALID;
			return a;
		end
		total = ADDR_W'(r.element_size) * ADDR_W'(r.element_count);
		// first free block that is long enough, no splitting
		for (i = 0; i < blk_count_m; i++) begin
			if (!blk_busy_m[i] && blk_len_m[i] >= total) begin
				blk_busy_m[i] = 1'b1;
				a.address = blk_base_m[i];
				a.clear_length = total;
				a.status = ST_OK;
				return a;
			end
		end
		// grow at heap top, if the table and the limit allow
		if (blk_count_m >= TBL || 34'(used_m) + 34'(total) > 34'(limit_m)) begin
			a.status = ST_NOMEM;
			return a;
		end
		blk_base_m[blk_count_m] = base_m + used_m[ADDR_W-1:0];
		blk_len_m[blk_count_m] = total;
		blk_busy_m[blk_count_m] = 1'b1;
		a.address = blk_base_m[blk_count_m];
		a.clear_length = total;
		a.status = ST_OK;
		blk_count_m++;
		used_m = used_m + USED_W'(total);
		return a;
	endfunction

	function automatic plan_row_t alloc_row(logic [ELEM_W-1:0] sz, logic [ELEM_W-1:0] cnt);
		plan_row_t p;
		p = '0;
		p.item.operation = OP_ALLOC;
		p.item.element_size = sz;
		p.item.element_count = cnt;
		return p;
	endfunction

	function automatic plan_row_t rel_row(logic [ADDR_W-1:0] addr);
		plan_row_t p;
		p = '0;
		p.item.operation = OP_RELEASE;
		p.item.release_address = addr;
		return p;
	endfunction

	function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		plan_row_t p;
		p = '0;
		p.is_cfg = 1'b1;
		p.cfg_idx = idx;
		p.cfg_val = val;
		return p;
	endfunction

	function automatic plan_row_t fixed_row(plan_row_t p, logic [ADDR_W-1:0] addr,
			logic [STAT_W-1:0] st, logic [ADDR_W-1:0] clr);
		plan_row_t q;
		q = p;
		q.fixed = 1'b1;
		q.fixed_rsp.address = addr;
		q.fixed_rsp.status = st;
		q.fixed_rsp.clear_length = clr;
		return q;
	endfunction

	// Mostly short gaps, some long ones, none while calm.
	function automatic int idle_gap();
		int pick;
		pick = $urandom_range(99);
		if (calm || pick < 55)
			return 0;
		if (pick < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Random request: mostly small allocations and releases of live bases,
	// so blocks get reused; the rest wide fields, zero fields, stray and null addresses.
	function automatic req_item_t random_item();
		req_item_t r;
		int        pick;
		r.operation = OP_ALLOC;
		r.element_size = ELEM_W'($urandom_range(64, 1));
		r.element_count = ELEM_W'($urandom_range(16, 1));
		r.release_address = $urandom;
		pick = $urandom_range(99);
		if (pick < 40) begin
			// small allocation, already set up
		end else if (pick < 47) begin
			r.element_size = ELEM_W'($urandom_range(4096, 1));
			r.element_count = ELEM_W'($urandom_range(8, 1));
		end else if (pick < 52) begin
			r.element_size = ELEM_W'($urandom);
			r.element_count = ELEM_W'($urandom);
		end else if (pick < 55) begin
			if ($urandom_range(1))
				r.element_size = '0;
			else
				r.element_count = '0;
		end else if (pick < 85) begin
			r.operation = OP_RELEASE;
			r.release_address = (blk_count_m == 0) ? '0 :
				blk_base_m[$urandom_range(blk_count_m - 1)];
		end else if (pick < 94) begin
			r.operation = OP_RELEASE;
		end else begin
			r.operation = OP_RELEASE;
			r.release_address = '0;
		end
		return r;
	endfunction

	// Offer one item and hold it until taken. The expectation is queued at the
	// accepting edge. valid drops afterwards on a gap or when lower is set.
	task automatic send_item(input req_item_t r, input logic fixed, input rsp_item_t fixed_rsp,
			input bit lower);
		rsp_item_t predicted;
		int        gap;
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted = alloc_answer(r);
		answers_due.push_back(fixed ? fixed_rsp : predicted);
		gap = idle_gap();
		if (lower || gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Register write, only once every outstanding result is back.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HEAP_BASE)
			base_m = val;
		else
			limit_m = val;
	endtask

	// Result side: compare each taken item with the oldest expectation.
	always @(posedge clk) begin : rsp_check
		rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_seen++;
			if (answers_due.size() == 0) begin
				$display("%0t: result with nothing expected: expected none, got addr %h status %0d clear %h",
					$time, rsp.address, rsp.status, rsp.clear_length);
				mismatches++;
			end else begin
				want = answers_due.pop_front();
				if (rsp.address !== want.address) begin
					$display("%0t: address expected %h got %h", $time, want.address, rsp.address);
					mismatches++;
				end
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
					mismatches++;
				end
				if (rsp.clear_length !== want.clear_length) begin
					$display("%0t: clear_length expected %h got %h", $time,
						want.clear_length, rsp.clear_length);
					mismatches++;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off after 200 results so the
	// output register and the item behind it back up and req_ready drops.
	always @(posedge clk) begin : rsp_side
		int pick;
		pick = $urandom_range(99);
		if (!squeeze_done && rsp_seen >= 200) begin
			squeeze_done = 1'b1;
			hold_left = 500;
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (calm || pick < 72) begin
			rsp_ready <= 1'b1;
		end else begin
			hold_left = (pick < 95) ? $urandom_range(2, 0) : $urandom_range(39, 9);
			rsp_ready <= 1'b0;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		plan_row_t plan [$];
		int        i;
		int        ph;
		int        k;
		int        len;

		for (i = 0; i < TBL; i++) begin
			blk_base_m[i] = '0;
			blk_len_m[i] = '0;
			blk_busy_m[i] = 1'b0;
		end

		// Directed part, starting from reset values (base 0, limit 64 KiB).
		// Null release and stray address on an empty table.
		plan.push_back(fixed_row(rel_row(32'h0), 32'h0, ST_OK, 32'h0));
		plan.push_back(fixed_row(rel_row(32'hFFFF_FFFF), 32'h0, ST_UNKNOWN, 32'h0));
		// Zero size or count is rejected.
		plan.push_back(fixed_row(alloc_row(16'd0, 16'd7), 32'h0, ST_INVALID, 32'h0));
		plan.push_back(fixed_row(alloc_row(16'd7, 16'd0), 32'h0, ST_INVALID, 32'h0));
		plan.push_back(fixed_row(alloc_row(16'd0, 16'd0), 32'h0, ST_INVALID, 32'h0));
		// First two growths from the heap base.
		plan.push_back(fixed_row(alloc_row(16'd16, 16'd4), 32'h0, ST_OK, 32'd64));
		plan.push_back(fixed_row(alloc_row(16'd1, 16'd1), 32'd64, ST_OK, 32'd1));
		// Largest products do not fit a 64 KiB heap.
		plan.push_back(fixed_row(alloc_row(16'hFFFF, 16'hFFFF), 32'h0, ST_NOMEM, 32'h0));
		plan.push_back(fixed_row(alloc_row(16'hFFFF, 16'd1), 32'h0, ST_NOMEM, 32'h0));
		plan.push_back(fixed_row(alloc_row(16'd1, 16'hFFFF), 32'h0, ST_NOMEM, 32'h0));
		// Free block 0, free it again, then reuse it with a shorter request.
		plan.push_back(rel_row(32'h0));
		plan.push_back(rel_row(32'h0));
		plan.push_back(alloc_row(16'd8, 16'd7));
		// Block at 64 is too short for 3 bytes, so this grows; 1 byte reuses it.
		plan.push_back(rel_row(32'd64));
		plan.push_back(alloc_row(16'd3, 16'd1));
		plan.push_back(alloc_row(16'd1, 16'd1));
		plan.push_back(alloc_row(16'h8000, 16'd1));
		// Limit dropped below usage: growth fails, free blocks still serve.
		plan.push_back(cfg_row(CFG_HEAP_LIMIT, 32'h0));
		plan.push_back(alloc_row(16'd1, 16'd1));
		plan.push_back(rel_row(32'd68));
		plan.push_back(alloc_row(16'h0100, 16'h0010));
		// Base near the top: the next block address wraps around zero.
		plan.push_back(cfg_row(CFG_HEAP_BASE, 32'hFFFF_FFF0));
		plan.push_back(cfg_row(CFG_HEAP_LIMIT, 32'hFFFF_FFFF));
		plan.push_back(alloc_row(16'h0010, 16'd2));
		// Usage is now 0x8064; this base makes the next growth land on address
		// 0 again, a duplicate of block 0. Release 0 must hit the older block.
		plan.push_back(cfg_row(CFG_HEAP_BASE, 32'hFFFF_7F9C));
		plan.push_back(alloc_row(16'h1000, 16'd1));
		plan.push_back(rel_row(32'h0));
		plan.push_back(alloc_row(16'd1, 16'd1));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (i = 0; i < plan.size(); i++) begin
			if (plan[i].is_cfg)
				set_reg(plan[i].cfg_idx, plan[i].cfg_val);
			else
				send_item(plan[i].item, plan[i].fixed, plan[i].fixed_rsp,
					i == plan.size() - 1 || plan[i + 1].is_cfg);
		end

		// Random part in four register settings: wide-open heap, zero limit with
		// the top base, a random base with a limit just above usage, and base 0.
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					set_reg(CFG_HEAP_BASE, 32'h1000_0000);
					set_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
				end
				1: begin
					set_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF);
					set_reg(CFG_HEAP_LIMIT, 32'h0);
				end
				2: begin
					set_reg(CFG_HEAP_BASE, $urandom);
					set_reg(CFG_HEAP_LIMIT, used_m[ADDR_W-1:0] + $urandom_range(100000));
				end
				default: begin
					set_reg(CFG_HEAP_BASE, 32'h0);
					set_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
				end
			endcase
			len = (ph == 1) ? 170 : 330;
			for (k = 0; k < len; k++) begin
				if (k % 64 == 0)
					calm = ($urandom_range(3) == 0);
				send_item(random_item(), 1'b0, '0, k == len - 1);
			end
		end

		// Drain, then leave room for any stray extra result.
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_ctrl.sv
hw/rtl/ffba_dp.sv
hw/rtl/first_fit_block_allocator_top.sv
tb/first_fit_block_allocator_top_tb.sv
